>>> sv/zrd_pkg.sv
// zrd_pkg: shared constants, register indexes and the run code decode for the
// zero run decoder. No dependencies.
`default_nettype none

package zrd_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int CODE_W          = 8;
  localparam int COUNT_W         = 9;
  localparam int LEVEL_W         = 2;
  localparam int INDEX_W         = 1;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_ZERO_LEVEL   = 1'b0,
    REG_FRAME_LENGTH = 1'b1
  } reg_index_t;

  localparam code_t RUN_HALF = 8'h80;

  // run code r -> 2r below 0x80, else ((-r)*2 - 1) & 0xff
  function automatic code_t run_decode(input code_t r);
    code_t neg;
    neg = code_t'(8'h00 - r);
    if (r < RUN_HALF) begin
      return {r[CODE_W-2:0], 1'b0};
    end
    return code_t'({neg[CODE_W-2:0], 1'b0} - 8'h01);
  endfunction

endpackage

`default_nettype wire

>>> sv/zero_run_decoder.sv
// zero_run_decoder: top level of the zero run expander, with state, result
// register and skid stage. Depends on zrd_pkg.
`default_nettype none

// One compressed byte is taken in every clock cycle while in_valid is high
// and in_stall is low. Each accepted byte updates the zero count and output
// count in the same cycle and, when it completes a literal or a run, loads
// one request into the result register, or into the skid register while the
// result register is held by a downstream stall. A skid register behind the
// result register keeps input acceptance going while the downstream side
// stalls, until one more request is waiting there; in_stall rises only when
// that skid register is full, and falls as its request moves into the result
// register. Zero bytes that only count towards a run code, and bytes that
// arrive after the frame length has been reached, give no request.
// Configuration writes take effect from the next byte.
module zero_run_decoder #(
  parameter int LENGTH_BITS = zrd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [zrd_pkg::INDEX_W-1:0] wr_index,
  input  wire logic [LENGTH_BITS-1:0]     wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [zrd_pkg::CODE_W-1:0] code_byte,
  input  wire logic                       frame_start,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [zrd_pkg::COUNT_W-1:0]     zero_count,
  output logic [zrd_pkg::CODE_W-1:0]      literal,
  output logic                            literal_valid,
  output logic                            done_res
);
  import zrd_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > COUNT_W) ? LENGTH_BITS : COUNT_W;

  typedef struct packed {
    count_t zcount;
    code_t  lit;
    logic   lit_valid;
    logic   done;
  } result_t;

  level_t                 zero_level;
  logic [LENGTH_BITS-1:0] frame_length;
  level_t                 zeros_seen;
  logic [LENGTH_BITS-1:0] bytes_out;
  logic                   finished;

  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  level_t                 level;
  level_t                 zs_eff;
  logic [LENGTH_BITS-1:0] bo_eff;
  logic                   fin_eff;
  logic [LENGTH_BITS-1:0] remaining;
  logic [CMP_W-1:0]       remaining_ext;
  count_t                 want;
  count_t                 zc;
  logic                   lit_ok;
  logic                   take;
  logic                   idle_frame;
  logic                   is_run;
  logic                   res_new;
  result_t                res;
  level_t                 zeros_seen_next;
  logic [LENGTH_BITS-1:0] bytes_out_next;
  logic                   finished_next;
  logic                   pop;

  assign in_stall = skid_valid;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    level         = (zero_level == '0) ? level_t'(1) : zero_level;
    zs_eff        = frame_start ? '0 : zeros_seen;
    bo_eff        = frame_start ? '0 : bytes_out;
    fin_eff       = frame_start ? 1'b0 : finished;
    idle_frame    = fin_eff || (bo_eff >= frame_length);
    remaining     = frame_length - bo_eff;
    remaining_ext = CMP_W'(remaining);
    is_run        = (zs_eff >= level);
    if (is_run) begin
      want = count_t'(run_decode(code_byte)) + count_t'(level);
    end else begin
      want = count_t'(zs_eff);
    end
    if (CMP_W'(want) < remaining_ext) begin
      zc = want;
    end else begin
      zc = count_t'(remaining_ext);
    end
    lit_ok = !is_run && (remaining_ext > CMP_W'(want));

    res_new         = 1'b0;
    zeros_seen_next = zs_eff;
    bytes_out_next  = bo_eff;
    finished_next   = fin_eff;
    if (!idle_frame) begin
      if (!is_run && (code_byte == '0)) begin
        zeros_seen_next = zs_eff + level_t'(1);
      end else begin
        res_new         = 1'b1;
        zeros_seen_next = '0;
        bytes_out_next  = bo_eff + LENGTH_BITS'(zc) + LENGTH_BITS'(lit_ok);
        finished_next   = (bytes_out_next >= frame_length);
      end
    end

    res.zcount    = zc;
    res.lit       = lit_ok ? code_byte : '0;
    res.lit_valid = lit_ok;
    res.done      = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level   <= level_t'(1);
      frame_length <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_ZERO_LEVEL:   zero_level   <= wr_data[LEVEL_W-1:0];
        REG_FRAME_LENGTH: frame_length <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zeros_seen <= '0;
      bytes_out  <= '0;
      finished   <= 1'b0;
    end else if (take) begin
      zeros_seen <= zeros_seen_next;
      bytes_out  <= bytes_out_next;
      finished   <= finished_next;
    end
  end

  // result register with skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= take && res_new;
          if (take && res_new) begin
            out_reg <= res;
          end
        end
      end else if (take && res_new) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign zero_count    = out_reg.zcount;
  assign literal       = out_reg.lit;
  assign literal_valid = out_reg.lit_valid;
  assign done_res      = out_reg.done;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a downstream stall");

  a_literal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && literal_valid) |-> (literal != '0))
    else $error("zero byte passed as literal");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_count <= count_t'(258)))
    else $error("zero count above longest run");

endmodule

`default_nettype wire

>>> tb/sv/zero_run_decoder_tb.sv
// zero_run_decoder_tb: self-checking testbench for the zero run expander, with its own
// prediction of each request and random idling on both channels.
// Depends on zrd_pkg and zero_run_decoder.
module zero_run_decoder_tb;
  import zrd_pkg::*;

  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam int IDLE_PCT = 38;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 6;
  localparam int RANDOM_BYTES = 1500;

  typedef struct packed {
    count_t zeros;
    code_t  lit;
    logic   lit_valid;
    logic   done;
  } run_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [INDEX_W-1:0] wr_index = '0;
  logic [LEN_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  code_t code_byte = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  count_t zero_count;
  code_t literal;
  logic literal_valid;
  logic done_res;

  // expected decoder state
  level_t cfg_level = 2'd1;
  logic [LEN_W-1:0] cfg_length = '0;
  logic [1:0] zeros_pending = '0;
  logic [LEN_W-1:0] bytes_emitted = '0;
  logic frame_done = 1'b0;
  int unsigned bytes_taken = 0;
  run_result_t expected_runs[$];

  int unsigned mismatches = 0;
  logic steady = 1'b0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  zero_run_decoder dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .code_byte(code_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .zero_count(zero_count),
    .literal(literal),
    .literal_valid(literal_valid),
    .done_res(done_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic expand_byte(input code_t b, input logic fs);
    logic [1:0] lvl;
    logic [LEN_W-1:0] room;
    logic [9:0] want;
    logic [LEN_W-1:0] zc;
    logic lit_ok;
    run_result_t r;
    lvl = (cfg_level == 2'd0) ? 2'd1 : cfg_level;
    lit_ok = 1'b0;
    if (fs) begin
      zeros_pending = '0;
      bytes_emitted = '0;
      frame_done = 1'b0;
    end
    if (frame_done || bytes_emitted >= cfg_length) return;
    bytes_taken++;
    room = cfg_length - bytes_emitted;
    if (zeros_pending >= lvl) begin
      // run code: low half doubles, upper half counts down from 255 in odd steps
      want = b[7] ? 10'(8'hff - {b[6:0], 1'b0}) : 10'({b[6:0], 1'b0});
      want = want + 10'(lvl);
      zc = (want < room) ? LEN_W'(want) : room;
      zeros_pending = '0;
    end else if (b == 8'h00) begin
      zeros_pending = zeros_pending + 2'd1;
      return;
    end else begin
      want = 10'(zeros_pending);
      zc = (want < room) ? LEN_W'(want) : room;
      lit_ok = room > want;
      zeros_pending = '0;
    end
    bytes_emitted = bytes_emitted + zc + LEN_W'(lit_ok);
    if (bytes_emitted >= cfg_length) frame_done = 1'b1;
    r.zeros = count_t'(zc);
    r.lit = lit_ok ? b : 8'h00;
    r.lit_valid = lit_ok;
    r.done = frame_done;
    expected_runs.push_back(r);
  endtask

  task automatic send_byte(input code_t b, input logic fs);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= b;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_byte(b, fs);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input level_t level, input logic [LEN_W-1:0] length);
    wr_en <= 1'b1;
    wr_index <= REG_ZERO_LEVEL;
    wr_data <= LEN_W'(level);
    @(posedge clk);
    wr_index <= REG_FRAME_LENGTH;
    wr_data <= length;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_level = level;
    cfg_length = length;
  endtask

  // receiver: random stalls, or a long hold-off when the token flips
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    run_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected request, expected none actual zeros=%0d lit=%0d/%0d done=%0d",
                 $time, zero_count, literal, literal_valid, done_res);
        mismatches++;
      end else begin
        e = expected_runs.pop_front();
        check_field("zero_count", e.zeros, zero_count);
        check_field("literal", e.lit, literal);
        check_field("literal_valid", e.lit_valid, literal_valid);
        check_field("done_res", e.done, done_res);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("zero_run_decoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset values: length zero, so every byte is dropped
  task automatic test_empty_frame;
    send_byte(8'h05, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_literals_and_runs;
    wait_drained();
    set_config(2'd1, LEN_W'(300));
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h33, 1'b0);
  endtask

  task automatic test_levels;
    wait_drained();
    set_config(2'd3, LEN_MAX);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h42, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_drained();
    set_config(2'd0, LEN_MAX);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_drained();
    set_config(2'd3, LEN_MAX);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // level dropped under the pending zeros
    wait_drained();
    set_config(2'd1, LEN_MAX);
    send_byte(8'h05, 1'b0);
  endtask

  task automatic test_clipping;
    wait_drained();
    set_config(2'd3, LEN_W'(3));
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    wait_drained();
    set_config(2'd3, LEN_W'(2));
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h44, 1'b0);
    wait_drained();
    set_config(2'd1, LEN_W'(1));
    send_byte(8'h07, 1'b1);
  endtask

  task automatic test_stall_fill;
    wait_drained();
    set_config(2'd2, LEN_MAX);
    steady <= 1'b1;
    hold_token <= ~hold_token;
    send_byte(8'h11, 1'b1);
    repeat (29) send_byte(code_t'($urandom_range(1, 255)), 1'b0);
    wait_drained();
    steady <= 1'b0;
  endtask

  task automatic test_random_frames;
    int unsigned goal;
    level_t lvl;
    logic [LEN_W-1:0] len;
    int unsigned n;
    int unsigned kind;
    int unsigned eff;
    int unsigned z;
    logic first;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          lvl = 2'd1;
          len = LEN_W'(1);
        end
        1: begin
          lvl = 2'd3;
          len = LEN_MAX;
        end
        default: begin
          lvl = level_t'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) len = LEN_W'($urandom_range(1, LEN_MAX));
          else len = LEN_W'($urandom_range(1, 600));
        end
      endcase
      set_config(lvl, len);
      steady <= (phase == 3);
      eff = (lvl == 2'd0) ? 1 : lvl;
      goal = bytes_taken + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_taken < goal) begin
        first = 1'b1;
        n = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
          kind = $urandom_range(0, 99);
          if (kind < 40) begin
            z = $urandom_range(0, eff - 1);
            repeat (z) begin
              send_byte(8'h00, first);
              first = 1'b0;
            end
            send_byte(code_t'($urandom_range(1, 255)), first);
          end else if (kind < 75) begin
            repeat (eff) begin
              send_byte(8'h00, first);
              first = 1'b0;
            end
            if ($urandom_range(0, 1) == 0) send_byte(code_t'($urandom_range(0, 7)), 1'b0);
            else send_byte(code_t'($urandom_range(0, 255)), 1'b0);
          end else if (kind < 92) begin
            send_byte(code_t'($urandom_range(0, 255)), first);
          end else begin
            send_byte(code_t'($urandom_range(0, 255)), first | 1'($urandom_range(0, 1)));
          end
          first = 1'b0;
          if (frame_done && $urandom_range(0, 3) != 0) break;
        end
      end
    end
    wait_drained();
    steady <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_frame();
    test_literals_and_runs();
    test_levels();
    test_clipping();
    test_stall_fill();
    test_random_frames();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("zero_run_decoder test passed");
    end else begin
      $display("zero_run_decoder test failed");
    end
    $finish;
  end

endmodule
